>>> src/motor_overcurrent_trip_detector_assert.svh
// Assertion macros for the overcurrent trip detector.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef MOTOR_OVERCURRENT_TRIP_DETECTOR_ASSERT_SVH
`define MOTOR_OVERCURRENT_TRIP_DETECTOR_ASSERT_SVH

// Same-cycle implication
`define MOCTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MOCTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/moctd_pkg.sv
// Shared types and constants for the overcurrent trip detector.
// No dependencies; used by moctd_eval and the top level.
package moctd_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_UPPER_LIMIT    = 3'd0;
  localparam logic [2:0] REG_LOWER_LIMIT    = 3'd1;
  localparam logic [2:0] REG_NEAR_WINDOW    = 3'd2;
  localparam logic [2:0] REG_RESET_WINDOW   = 3'd3;
  localparam logic [2:0] REG_TRIP_LIMIT     = 3'd4;
  localparam logic [2:0] REG_RECOVERY_TICKS = 3'd5;

  // Register reset values
  localparam logic signed [15:0] UPPER_LIMIT_RST    = 16'sd20000;
  localparam logic signed [15:0] LOWER_LIMIT_RST    = -16'sd20000;
  localparam logic [7:0]         NEAR_WINDOW_RST    = 8'd10;
  localparam logic [7:0]         RESET_WINDOW_RST   = 8'd50;
  localparam logic [7:0]         TRIP_LIMIT_RST     = 8'd30;
  localparam logic [15:0]        RECOVERY_TICKS_RST = 16'd5000;

  localparam logic [7:0] BURST_MAX = 8'd255;

  typedef struct packed {
    logic [31:0]        now_ticks;
    logic               motor_running;
    logic signed [15:0] current_d;
    logic signed [15:0] current_q;
  } in_word_t;

  typedef struct packed {
    logic        stop_motor;
    logic        fault_active;
    logic        fault_cleared;
    logic [15:0] trip_total;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] upper_limit;
    logic signed [15:0] lower_limit;
    logic [7:0]         near_window;
    logic [7:0]         reset_window;
    logic [7:0]         trip_limit;
    logic [15:0]        recovery_ticks;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  burst_count;
    logic [31:0] last_overload_time;
    logic        fault_latched;
    logic [15:0] trip_counter;
  } det_state_t;

endpackage

>>> src/moctd_eval.sv
// One detection pass: next detector state and result word from the current
// state, configuration and input word. Depends on moctd_pkg.
module moctd_eval (
  input  moctd_pkg::in_word_t   item,
  input  moctd_pkg::cfg_t       cfg,
  input  moctd_pkg::det_state_t cur,
  output moctd_pkg::det_state_t nxt,
  output moctd_pkg::out_word_t  res
);

  logic [31:0] gap;
  logic        clear_hit;
  logic        over_d;
  logic        over_q;
  logic        overload;
  logic        near_hit;
  logic        far_hit;
  logic [7:0]  burst_inc;
  logic        trip_hit;

  // Gap to the last overload, modulo 2^32
  assign gap = item.now_ticks - cur.last_overload_time;

  // Recovery check comes first
  assign clear_hit = cur.fault_latched && (gap >= {16'd0, cfg.recovery_ticks});

  // Overload detection on both axes
  assign over_d = ($signed(item.current_d) >= $signed(cfg.upper_limit)) ||
                  ($signed(item.current_d) <= $signed(cfg.lower_limit));
  assign over_q = ($signed(item.current_q) >= $signed(cfg.upper_limit)) ||
                  ($signed(item.current_q) <= $signed(cfg.lower_limit));
  assign overload = item.motor_running && (over_d || over_q);

  // Burst classification; saturate the increment
  assign near_hit  = gap <= {24'd0, cfg.near_window};
  assign far_hit   = gap >= {24'd0, cfg.reset_window};
  assign burst_inc = (cur.burst_count == moctd_pkg::BURST_MAX) ?
                     cur.burst_count : cur.burst_count + 8'd1;
  assign trip_hit  = overload && near_hit && (burst_inc >= cfg.trip_limit);

  // Advance state
  always_comb begin
    nxt = cur;
    if (clear_hit) begin
      nxt.fault_latched = 1'b0;
    end
    if (overload) begin
      nxt.last_overload_time = item.now_ticks;
      if (near_hit) begin
        nxt.burst_count = burst_inc;
        if (trip_hit) begin
          nxt.burst_count   = 8'd0;
          nxt.fault_latched = 1'b1;
          nxt.trip_counter  = cur.trip_counter + 16'd1;
        end
      end else if (far_hit) begin
        nxt.burst_count = 8'd0;
      end
    end
  end

  // Build the result word
  always_comb begin
    res.stop_motor    = trip_hit;
    res.fault_active  = nxt.fault_latched;
    res.fault_cleared = clear_hit;
    res.trip_total    = nxt.trip_counter;
  end

endmodule

>>> src/motor_overcurrent_trip_detector.sv
// Overcurrent trip detector: an accepted word is held in the input register, and its result
// is then loaded into the output register once that register is free to take it.
// Throughput one word per cycle while the output is not stalled; the input register feeds one detection pass
// whose result lands in the output register as the detector state updates.
// Synchronous active-low reset clears state to zero and registers to defaults.
// Depends on moctd_pkg, moctd_eval and the assertion macro header.
module motor_overcurrent_trip_detector (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  moctd_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output moctd_pkg::out_word_t out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_wdata
);

  `include "motor_overcurrent_trip_detector_assert.svh"

  moctd_pkg::cfg_t       cfg_r;
  moctd_pkg::det_state_t state_r;
  moctd_pkg::det_state_t state_nxt;
  moctd_pkg::in_word_t   item_r;
  logic                  item_valid_r;
  logic                  item_valid_nxt;
  moctd_pkg::out_word_t  res_nxt;
  moctd_pkg::out_word_t  out_data_r;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic                  in_accept;
  logic                  adv;
  logic                  out_load;

  // Handshake: the result register drains or refills every cycle it can
  assign adv       = !out_valid_r || !out_stall;
  assign out_load  = item_valid_r && adv;
  assign in_stall  = item_valid_r && !adv;
  assign in_accept = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.upper_limit    <= moctd_pkg::UPPER_LIMIT_RST;
      cfg_r.lower_limit    <= moctd_pkg::LOWER_LIMIT_RST;
      cfg_r.near_window    <= moctd_pkg::NEAR_WINDOW_RST;
      cfg_r.reset_window   <= moctd_pkg::RESET_WINDOW_RST;
      cfg_r.trip_limit     <= moctd_pkg::TRIP_LIMIT_RST;
      cfg_r.recovery_ticks <= moctd_pkg::RECOVERY_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        moctd_pkg::REG_UPPER_LIMIT:    cfg_r.upper_limit    <= cfg_wdata;
        moctd_pkg::REG_LOWER_LIMIT:    cfg_r.lower_limit    <= cfg_wdata;
        moctd_pkg::REG_NEAR_WINDOW:    cfg_r.near_window    <= cfg_wdata[7:0];
        moctd_pkg::REG_RESET_WINDOW:   cfg_r.reset_window   <= cfg_wdata[7:0];
        moctd_pkg::REG_TRIP_LIMIT:     cfg_r.trip_limit     <= cfg_wdata[7:0];
        moctd_pkg::REG_RECOVERY_TICKS: cfg_r.recovery_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Detection pass
  moctd_eval u_eval (
    .item (item_r),
    .cfg  (cfg_r),
    .cur  (state_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  // Valid flags for the two stages
  always_comb begin
    item_valid_nxt = item_valid_r;
    if (in_accept) begin
      item_valid_nxt = 1'b1;
    end else if (adv) begin
      item_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and detector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      state_r      <= '0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (out_load) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_data;
    end
    if (out_load) begin
      out_data_r <= res_nxt;
    end
  end

  // Checks
  `MOCTD_ASSERT_NOW(a_stop_latches, out_valid_r && out_data_r.stop_motor, out_data_r.fault_active, "stop without latched fault")
  `MOCTD_ASSERT_NOW(a_stall_needs_item, in_stall, item_valid_r && out_valid_r, "input stalled with free stage")
  `MOCTD_ASSERT_NEXT(a_state_holds, !out_load, $stable(state_r), "detector state moved without a pass")
  `MOCTD_ASSERT_NEXT(a_trip_clears_burst, out_load && res_nxt.stop_motor, state_r.burst_count == 8'd0, "burst count not cleared on trip")

endmodule

>>> bench/motor_overcurrent_trip_detector_test.sv
// Self-checking bench for the motor overcurrent trip detector: random and directed current words.
// A built-in predictor computes the expected result of every word, and the results are checked in order.
// Depends on moctd_pkg and the motor_overcurrent_trip_detector top level.
module motor_overcurrent_trip_detector_test;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_WORDS   = 128;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  moctd_pkg::in_word_t  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  moctd_pkg::out_word_t out_data;
  logic                 cfg_we = 1'b0;
  logic [2:0]           cfg_index = moctd_pkg::REG_UPPER_LIMIT;
  logic [15:0]          cfg_wdata = '0;

  // Predictor copy of the registers and the detector state
  moctd_pkg::cfg_t       lim;
  moctd_pkg::det_state_t det;

  // Stimulus and scoreboard storage
  moctd_pkg::in_word_t  samples_pending[$];
  moctd_pkg::out_word_t trip_reports_due[$];
  moctd_pkg::cfg_t      plan;
  logic [31:0] tick_now;
  bit         calm;
  bit         in_taken;
  int         words_queued;
  int         words_accepted;
  int         results_checked;
  int         trips_seen;
  int         clears_seen;
  int         settings_used;
  int         mismatches;
  int         send_gap;
  int         stall_left;
  int         cycle_count;

  motor_overcurrent_trip_detector u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // One detection pass: recovery check first, then overload and burst handling
  function automatic moctd_pkg::out_word_t detect_pass(moctd_pkg::in_word_t w);
    moctd_pkg::out_word_t r;
    logic [31:0] gap;
    logic        over;
    r = '0;
    gap = w.now_ticks - det.last_overload_time;
    if (det.fault_latched && gap >= {16'd0, lim.recovery_ticks}) begin
      det.fault_latched = 1'b0;
      r.fault_cleared = 1'b1;
    end
    over = ($signed(w.current_d) >= $signed(lim.upper_limit)) ||
           ($signed(w.current_d) <= $signed(lim.lower_limit)) ||
           ($signed(w.current_q) >= $signed(lim.upper_limit)) ||
           ($signed(w.current_q) <= $signed(lim.lower_limit));
    if (w.motor_running && over) begin
      if (gap <= {24'd0, lim.near_window}) begin
        if (det.burst_count != moctd_pkg::BURST_MAX) det.burst_count = det.burst_count + 8'd1;
        if (det.burst_count >= lim.trip_limit) begin
          r.stop_motor = 1'b1;
          det.burst_count = '0;
          det.fault_latched = 1'b1;
          det.trip_counter = det.trip_counter + 16'd1;
        end
      end else if (gap >= {24'd0, lim.reset_window}) begin
        det.burst_count = '0;
      end
      det.last_overload_time = w.now_ticks;
    end
    r.fault_active = det.fault_latched;
    r.trip_total = det.trip_counter;
    return r;
  endfunction

  // Idle length for either side: mostly none or short, a few long
  function automatic int pick_idle();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Current sample that is over a limit, or one strictly inside the limits (random if they leave no room)
  function automatic logic [15:0] pick_current(bit want_over);
    int up;
    int lo;
    int v;
    up = $signed(plan.upper_limit);
    lo = $signed(plan.lower_limit);
    if (want_over) begin
      if ($urandom_range(0, 1)) v = up + int'($urandom_range(0, 32767 - up));
      else v = lo - int'($urandom_range(0, lo + 32768));
    end else if (lo + 1 <= up - 1) begin
      v = lo + 1 + int'($urandom_range(0, up - lo - 2));
    end else begin
      v = $urandom;
    end
    return v[15:0];
  endfunction

  // Tick advance: mostly within the burst window, sometimes across the others
  function automatic logic [31:0] pick_gap_ticks();
    int unsigned r;
    int unsigned nw;
    int unsigned rw;
    r = $urandom_range(0, 99);
    nw = plan.near_window;
    rw = plan.reset_window;
    if (r < 62) return $urandom_range(0, nw);
    if (r < 75) return nw + 1 + $urandom_range(0, (rw > nw + 1) ? rw - nw - 1 : 3);
    if (r < 85) return rw + $urandom_range(0, 20);
    if (r < 92) return {16'd0, plan.recovery_ticks} + $urandom_range(0, 4) - 2;
    if (r < 96) return $urandom;
    return 0;
  endfunction

  function automatic moctd_pkg::in_word_t make_word();
    moctd_pkg::in_word_t w;
    int unsigned r;
    tick_now = tick_now + pick_gap_ticks();
    w.now_ticks = tick_now;
    w.motor_running = 1'b1;
    r = $urandom_range(0, 99);
    if (r < 72) begin
      case ($urandom_range(0, 2))
        0: begin
          w.current_d = pick_current(1'b1);
          w.current_q = pick_current(1'b0);
        end
        1: begin
          w.current_d = pick_current(1'b0);
          w.current_q = pick_current(1'b1);
        end
        default: begin
          w.current_d = pick_current(1'b1);
          w.current_q = pick_current(1'b1);
        end
      endcase
    end else if (r < 85) begin
      w.current_d = pick_current(1'b0);
      w.current_q = pick_current(1'b0);
    end else begin
      w.motor_running = (r < 95) ? 1'b0 : 1'($urandom_range(0, 1));
      w.current_d = 16'($urandom);
      w.current_q = 16'($urandom);
    end
    return w;
  endfunction

  function automatic moctd_pkg::in_word_t mk(logic [31:0] t, logic run, logic [15:0] d,
                                             logic [15:0] q);
    moctd_pkg::in_word_t w;
    w.now_ticks = t;
    w.motor_running = run;
    w.current_d = d;
    w.current_q = q;
    return w;
  endfunction

  function automatic moctd_pkg::cfg_t pick_plan(int p);
    moctd_pkg::cfg_t c;
    int   tmp;
    c.upper_limit = 16'($urandom_range(0, 30000));
    tmp = $urandom_range(0, 30000);
    c.lower_limit = 16'(-tmp);
    c.near_window = 8'($urandom_range(0, 40));
    c.reset_window = 8'($urandom_range(0, 80));
    c.trip_limit = 8'($urandom_range(1, 8));
    c.recovery_ticks = 16'($urandom_range(0, 200));
    case (p)
      0: c = '{16'sh7FFF, 16'sh8000, 8'd0, 8'd0, 8'd1, 16'd0};
      1: c = '{16'sh8000, 16'sh7FFF, 8'd255, 8'd255, 8'd255, 16'hFFFF};
      2: c.trip_limit = 8'd0;
      3: begin
        c.near_window = 8'd255;
        c.reset_window = 8'd0;
        c.trip_limit = 8'd3;
        c.recovery_ticks = 16'hFFFF;
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic queue_word(moctd_pkg::in_word_t w);
    samples_pending.push_back(w);
    words_queued++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  // Write every register; narrow registers carry junk in the unused upper bits
  task automatic apply_plan(moctd_pkg::cfg_t c);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(moctd_pkg::REG_UPPER_LIMIT, c.upper_limit);
    write_reg(moctd_pkg::REG_LOWER_LIMIT, c.lower_limit);
    write_reg(moctd_pkg::REG_NEAR_WINDOW, {junk[7:0], c.near_window});
    write_reg(moctd_pkg::REG_RESET_WINDOW, {junk[15:8], c.reset_window});
    write_reg(moctd_pkg::REG_TRIP_LIMIT, {junk[23:16], c.trip_limit});
    write_reg(moctd_pkg::REG_RECOVERY_TICKS, c.recovery_ticks);
    @(negedge clk);
    cfg_we <= 1'b0;
    plan = c;
    settings_used++;
  endtask

  // Hold off until every queued word is accepted and answered, then let the pipe empty
  task automatic settle();
    do @(negedge clk);
    while (words_accepted != words_queued || trip_reports_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Driver: advance to the next pending word once the current one is taken
  always @(negedge clk) begin
    if (!(in_valid && !in_taken)) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap = send_gap - 1;
      end else if (samples_pending.size() != 0) begin
        in_data <= samples_pending.pop_front();
        in_valid <= 1'b1;
        send_gap = pick_idle();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_idle();
    end
  end

  // Monitor: check results, track register writes, predict accepted words
  always @(posedge clk) begin
    moctd_pkg::out_word_t want;
    if (!rst_n) begin
      lim = '{moctd_pkg::UPPER_LIMIT_RST, moctd_pkg::LOWER_LIMIT_RST,
              moctd_pkg::NEAR_WINDOW_RST, moctd_pkg::RESET_WINDOW_RST,
              moctd_pkg::TRIP_LIMIT_RST, moctd_pkg::RECOVERY_TICKS_RST};
      det = '0;
      in_taken = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (trip_reports_due.size() == 0) begin
          $error("result word with no prediction waiting");
          mismatches++;
        end else begin
          want = trip_reports_due.pop_front();
          results_checked++;
          if (out_data.stop_motor) trips_seen++;
          if (out_data.fault_cleared) clears_seen++;
          if (out_data.stop_motor !== want.stop_motor) begin
            $error("stop_motor: expected %0d, got %0d", want.stop_motor, out_data.stop_motor);
            mismatches++;
          end
          if (out_data.fault_active !== want.fault_active) begin
            $error("fault_active: expected %0d, got %0d", want.fault_active,
                   out_data.fault_active);
            mismatches++;
          end
          if (out_data.fault_cleared !== want.fault_cleared) begin
            $error("fault_cleared: expected %0d, got %0d", want.fault_cleared,
                   out_data.fault_cleared);
            mismatches++;
          end
          if (out_data.trip_total !== want.trip_total) begin
            $error("trip_total: expected %0d, got %0d", want.trip_total, out_data.trip_total);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          moctd_pkg::REG_UPPER_LIMIT:    lim.upper_limit = cfg_wdata;
          moctd_pkg::REG_LOWER_LIMIT:    lim.lower_limit = cfg_wdata;
          moctd_pkg::REG_NEAR_WINDOW:    lim.near_window = cfg_wdata[7:0];
          moctd_pkg::REG_RESET_WINDOW:   lim.reset_window = cfg_wdata[7:0];
          moctd_pkg::REG_TRIP_LIMIT:     lim.trip_limit = cfg_wdata[7:0];
          moctd_pkg::REG_RECOVERY_TICKS: lim.recovery_ticks = cfg_wdata;
          default: ;
        endcase
      end
      in_taken = in_valid && !in_stall;
      if (in_taken) begin
        trip_reports_due.push_back(detect_pass(in_data));
        words_accepted++;
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("motor_overcurrent_trip_detector_test failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: limit edges, burst trip, stopped motor, recovery, window edges
    apply_plan('{16'sd20000, -16'sd20000, 8'd10, 8'd50, 8'd2, 16'd20});
    queue_word(mk(32'd0, 1'b1, 16'h7FFF, 16'h0000));
    queue_word(mk(32'd5, 1'b1, 16'h0000, 16'h8000));
    queue_word(mk(32'd6, 1'b0, 16'h7FFF, 16'h8000));
    queue_word(mk(32'd25, 1'b0, 16'h0000, 16'h0000));
    queue_word(mk(32'd30, 1'b1, 16'sd20000, 16'h0000));
    queue_word(mk(32'd40, 1'b1, 16'sd19999, -16'sd19999));
    queue_word(mk(32'd40, 1'b1, 16'h0000, -16'sd20000));
    queue_word(mk(32'd90, 1'b1, 16'h8000, 16'h0000));
    queue_word(mk(32'd100, 1'b1, 16'h7FFF, 16'h7FFF));
    queue_word(mk(32'd110, 1'b1, 16'h8000, 16'h8000));
    queue_word(mk(32'd130, 1'b1, 16'h7FFF, 16'h0000));
    queue_word(mk(32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF));
    settle();

    // Directed: time wrap, overlapping windows, clear and trip in one pass
    apply_plan('{16'sd100, -16'sd100, 8'd10, 8'd5, 8'd1, 16'd3});
    queue_word(mk(32'hFFFF_FFFA, 1'b1, 16'sd100, 16'h0000));
    queue_word(mk(32'd2, 1'b1, -16'sd100, 16'h0000));
    queue_word(mk(32'd6, 1'b1, 16'h0000, 16'h7FFF));
    queue_word(mk(32'd6, 1'b1, 16'sd99, -16'sd99));
    queue_word(mk(32'd7, 1'b0, 16'h0000, 16'h8000));
    queue_word(mk(32'd20, 1'b0, 16'h0000, 16'h0000));
    queue_word(mk(32'd21, 1'b1, 16'h5555, 16'hAAAA));
    settle();

    // Random phases, each under its own register setting
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_plan(pick_plan(p));
      calm = ($urandom_range(0, 3) == 0);
      tick_now = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom;
      repeat (PHASE_WORDS) queue_word(make_word());
      settle();
    end

    $display("%0d words sent under %0d register settings, %0d results checked",
             words_queued, settings_used, results_checked);
    $display("%0d trips and %0d fault clears observed", trips_seen, clears_seen);
    if (mismatches == 0 && trip_reports_due.size() == 0) begin
      $display("motor_overcurrent_trip_detector_test passed");
    end else begin
      $display("motor_overcurrent_trip_detector_test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/moctd_pkg.sv
src/moctd_eval.sv
src/motor_overcurrent_trip_detector.sv
bench/motor_overcurrent_trip_detector_test.sv
